// ----- src/btffa_pkg.sv -----
// Package: types, constants and codes of the boundary tag first fit allocator.
`timescale 1ns / 1ps
package btffa_pkg;
    localparam int ArenaCap  = 65536;
    localparam int TagBytes  = 8;
    localparam int TagSpan   = (TagBytes + 1) / 2 * 2;
    localparam int TagDepth  = ArenaCap / 2;
    localparam int AddrW     = $clog2(TagDepth);
    localparam int TagW      = 16;
    localparam int OffW      = 18;
    localparam int CfgW      = 17;
    localparam int MinSplit  = 6;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_FREE   = 2'd2,
        KIND_CHECK  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] request_size;
        logic [15:0] payload_offset;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [15:0] alloc_offset;
        logic        owned;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FMT0, ST_FMT1, ST_FMT2, ST_TEST, ST_LAT, ST_DEC,
        ST_A0, ST_A1, ST_A2, ST_A3, ST_N0, ST_N1,
        ST_NXT_RD, ST_NXT_LAT, ST_PRV_RD, ST_PRV_LAT, ST_F0, ST_F1, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_FMT0, OP_FMT1, OP_FMT2, OP_RD_P, OP_LAT_P,
        OP_ADV, OP_FAIL, OP_ALLOC_OK, OP_CHK, OP_FREE_INIT,
        OP_WR_A0, OP_WR_A1, OP_WR_A2, OP_WR_A3, OP_WR_N0, OP_WR_N1,
        OP_RD_NXT, OP_LAT_NXT, OP_RD_PRV, OP_LAT_PRV, OP_WR_F0, OP_WR_F1
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_end;
        logic used;
        logic fits;
        logic split;
        logic hit;
        logic past;
        logic inr;
        logic nxt_in;
        logic p_gt;
    } t_dp_stat;
endpackage

// ----- src/btffa_ctrl.sv -----
// Controller: sequences format, tag walk, block marking and merging.
`timescale 1ns / 1ps
module btffa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  btffa_pkg::t_kind    i_kind,
    input  btffa_pkg::t_dp_stat i_stat,
    output btffa_pkg::t_dp_cmd  o_cmd,
    output logic                o_busy,
    output logic                o_done
);
    btffa_pkg::t_state r_state, n_state;
    btffa_pkg::t_kind  r_kind, n_kind;
    logic              r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btffa_pkg::ST_FMT0;
            r_kind  <= btffa_pkg::KIND_FORMAT;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_boot  = r_boot;
        unique case (r_state)
            btffa_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_kind  = i_kind;
                    n_state = (i_kind == btffa_pkg::KIND_FORMAT) ?
                              btffa_pkg::ST_FMT0 : btffa_pkg::ST_TEST;
                end
            end
            btffa_pkg::ST_FMT0: n_state = btffa_pkg::ST_FMT1;
            btffa_pkg::ST_FMT1: n_state = btffa_pkg::ST_FMT2;
            btffa_pkg::ST_FMT2: begin
                n_boot  = 1'b0;
                n_state = r_boot ? btffa_pkg::ST_IDLE : btffa_pkg::ST_DONE;
            end
            btffa_pkg::ST_TEST:
                n_state = i_stat.walk_end ? btffa_pkg::ST_DONE : btffa_pkg::ST_LAT;
            btffa_pkg::ST_LAT: n_state = btffa_pkg::ST_DEC;
            btffa_pkg::ST_DEC: begin
                unique case (r_kind)
                    btffa_pkg::KIND_ALLOC: begin
                        if (i_stat.fits)
                            n_state = i_stat.split ? btffa_pkg::ST_A0 : btffa_pkg::ST_N0;
                        else
                            n_state = btffa_pkg::ST_TEST;
                    end
                    btffa_pkg::KIND_FREE: begin
                        if (i_stat.hit) begin
                            if (!i_stat.used)
                                n_state = btffa_pkg::ST_DONE;
                            else if (i_stat.nxt_in)
                                n_state = btffa_pkg::ST_NXT_RD;
                            else if (i_stat.p_gt)
                                n_state = btffa_pkg::ST_PRV_RD;
                            else
                                n_state = btffa_pkg::ST_F0;
                        end else if (i_stat.past) begin
                            n_state = btffa_pkg::ST_DONE;
                        end else begin
                            n_state = btffa_pkg::ST_TEST;
                        end
                    end
                    default:
                        n_state = i_stat.inr ? btffa_pkg::ST_DONE : btffa_pkg::ST_TEST;
                endcase
            end
            btffa_pkg::ST_A0: n_state = btffa_pkg::ST_A1;
            btffa_pkg::ST_A1: n_state = btffa_pkg::ST_A2;
            btffa_pkg::ST_A2: n_state = btffa_pkg::ST_A3;
            btffa_pkg::ST_A3: n_state = btffa_pkg::ST_DONE;
            btffa_pkg::ST_N0: n_state = btffa_pkg::ST_N1;
            btffa_pkg::ST_N1: n_state = btffa_pkg::ST_DONE;
            btffa_pkg::ST_NXT_RD: n_state = btffa_pkg::ST_NXT_LAT;
            btffa_pkg::ST_NXT_LAT:
                n_state = i_stat.p_gt ? btffa_pkg::ST_PRV_RD : btffa_pkg::ST_F0;
            btffa_pkg::ST_PRV_RD: n_state = btffa_pkg::ST_PRV_LAT;
            btffa_pkg::ST_PRV_LAT: n_state = btffa_pkg::ST_F0;
            btffa_pkg::ST_F0: n_state = btffa_pkg::ST_F1;
            btffa_pkg::ST_F1: n_state = btffa_pkg::ST_DONE;
            btffa_pkg::ST_DONE: n_state = btffa_pkg::ST_IDLE;
            default: n_state = btffa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = btffa_pkg::OP_NONE;
        o_busy   = (r_state != btffa_pkg::ST_IDLE);
        o_done   = (r_state == btffa_pkg::ST_DONE);
        unique case (r_state)
            btffa_pkg::ST_IDLE: if (i_start) o_cmd.op = btffa_pkg::OP_LOAD;
            btffa_pkg::ST_FMT0: o_cmd.op = btffa_pkg::OP_FMT0;
            btffa_pkg::ST_FMT1: o_cmd.op = btffa_pkg::OP_FMT1;
            btffa_pkg::ST_FMT2: o_cmd.op = btffa_pkg::OP_FMT2;
            btffa_pkg::ST_TEST:
                o_cmd.op = i_stat.walk_end ? btffa_pkg::OP_FAIL : btffa_pkg::OP_RD_P;
            btffa_pkg::ST_LAT: o_cmd.op = btffa_pkg::OP_LAT_P;
            btffa_pkg::ST_DEC: begin
                unique case (r_kind)
                    btffa_pkg::KIND_ALLOC:
                        o_cmd.op = i_stat.fits ? btffa_pkg::OP_ALLOC_OK : btffa_pkg::OP_ADV;
                    btffa_pkg::KIND_FREE: begin
                        if (i_stat.hit)
                            o_cmd.op = i_stat.used ? btffa_pkg::OP_FREE_INIT :
                                                     btffa_pkg::OP_FAIL;
                        else if (i_stat.past)
                            o_cmd.op = btffa_pkg::OP_FAIL;
                        else
                            o_cmd.op = btffa_pkg::OP_ADV;
                    end
                    default:
                        o_cmd.op = i_stat.inr ? btffa_pkg::OP_CHK : btffa_pkg::OP_ADV;
                endcase
            end
            btffa_pkg::ST_A0: o_cmd.op = btffa_pkg::OP_WR_A0;
            btffa_pkg::ST_A1: o_cmd.op = btffa_pkg::OP_WR_A1;
            btffa_pkg::ST_A2: o_cmd.op = btffa_pkg::OP_WR_A2;
            btffa_pkg::ST_A3: o_cmd.op = btffa_pkg::OP_WR_A3;
            btffa_pkg::ST_N0: o_cmd.op = btffa_pkg::OP_WR_N0;
            btffa_pkg::ST_N1: o_cmd.op = btffa_pkg::OP_WR_N1;
            btffa_pkg::ST_NXT_RD: o_cmd.op = btffa_pkg::OP_RD_NXT;
            btffa_pkg::ST_NXT_LAT: o_cmd.op = btffa_pkg::OP_LAT_NXT;
            btffa_pkg::ST_PRV_RD: o_cmd.op = btffa_pkg::OP_RD_PRV;
            btffa_pkg::ST_PRV_LAT: o_cmd.op = btffa_pkg::OP_LAT_PRV;
            btffa_pkg::ST_F0: o_cmd.op = btffa_pkg::OP_WR_F0;
            btffa_pkg::ST_F1: o_cmd.op = btffa_pkg::OP_WR_F1;
            default: o_cmd.op = btffa_pkg::OP_NONE;
        endcase
    end
endmodule

// ----- src/btffa_dp.sv -----
// Datapath: tag memory, walk pointer, block sizes and result word.
`timescale 1ns / 1ps
module btffa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  btffa_pkg::t_dp_cmd              i_cmd,
    input  btffa_pkg::t_in_word             i_word,
    input  logic                            i_cfg_we,
    input  logic [btffa_pkg::CfgW-1:0]      i_cfg_wdata,
    output btffa_pkg::t_dp_stat             o_stat,
    output btffa_pkg::t_out_word            o_word
);
    localparam int OW = btffa_pkg::OffW;
    localparam logic [OW-1:0] T1 = OW'(btffa_pkg::TagSpan);
    localparam logic [OW-1:0] T2 = OW'(2 * btffa_pkg::TagSpan);
    localparam logic [OW-1:0] T3 = OW'(3 * btffa_pkg::TagSpan);
    localparam logic [OW-1:0] SplitMin = OW'(2 * btffa_pkg::TagSpan + btffa_pkg::MinSplit);
    localparam logic [OW-1:0] Cap = OW'(btffa_pkg::ArenaCap);

    logic [btffa_pkg::TagW-1:0] r_mem [btffa_pkg::TagDepth];
    logic [btffa_pkg::TagW-1:0] r_rdata;
    logic [btffa_pkg::CfgW-1:0] r_cfg;
    logic [OW-1:0] r_end, r_a, r_p, r_s, r_need, r_off, r_hdr, r_sz;
    logic          r_used;
    btffa_pkg::t_out_word r_res;

    logic [OW-1:0] a_round, a_clamp, rd_s, rem, mem_addr;
    logic [btffa_pkg::TagW-1:0] mem_wdata;
    logic          mem_we, mem_re;

    assign a_round = ({1'b0, r_cfg} + OW'(1)) & ~OW'(1);
    assign a_clamp = (a_round < T3) ? T3 : ((a_round > Cap) ? Cap : a_round);
    assign rd_s    = {{(OW - btffa_pkg::TagW){1'b0}}, r_rdata[btffa_pkg::TagW-1:1], 1'b0};
    assign rem     = r_s - r_need - T2;

    assign o_stat.walk_end = (r_p >= r_end);
    assign o_stat.used     = r_used;
    assign o_stat.fits     = !r_used && (r_s >= r_need);
    assign o_stat.split    = (r_s - r_need) >= SplitMin;
    assign o_stat.hit      = (r_p + T1) == r_off;
    assign o_stat.past     = (r_p + T1) > r_off;
    assign o_stat.inr      = (r_off >= r_p + T1) && (r_off < r_p + T1 + r_s);
    assign o_stat.nxt_in   = (r_p + T2 + r_s) < r_end;
    assign o_stat.p_gt     = r_p > T1;
    assign o_word          = r_res;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_p;
        mem_wdata = '0;
        case (i_cmd.op)
            btffa_pkg::OP_FMT0: begin
                mem_we = 1'b1; mem_addr = '0;
                mem_wdata = btffa_pkg::TagW'(a_clamp - T1);
            end
            btffa_pkg::OP_FMT1: begin
                mem_we = 1'b1; mem_addr = T1;
                mem_wdata = btffa_pkg::TagW'(r_a - T3);
            end
            btffa_pkg::OP_FMT2: begin
                mem_we = 1'b1; mem_addr = r_a - T1;
                mem_wdata = btffa_pkg::TagW'(r_a - T3);
            end
            btffa_pkg::OP_RD_P: mem_re = 1'b1;
            btffa_pkg::OP_WR_A0: begin
                mem_we = 1'b1; mem_wdata = btffa_pkg::TagW'(r_need | OW'(1));
            end
            btffa_pkg::OP_WR_A1: begin
                mem_we = 1'b1; mem_addr = r_p + T1 + r_need;
                mem_wdata = btffa_pkg::TagW'(r_need | OW'(1));
            end
            btffa_pkg::OP_WR_A2: begin
                mem_we = 1'b1; mem_addr = r_p + T2 + r_need;
                mem_wdata = btffa_pkg::TagW'(rem);
            end
            btffa_pkg::OP_WR_A3: begin
                mem_we = 1'b1; mem_addr = r_p + T1 + r_s;
                mem_wdata = btffa_pkg::TagW'(rem);
            end
            btffa_pkg::OP_WR_N0: begin
                mem_we = 1'b1; mem_wdata = btffa_pkg::TagW'(r_s | OW'(1));
            end
            btffa_pkg::OP_WR_N1: begin
                mem_we = 1'b1; mem_addr = r_p + T1 + r_s;
                mem_wdata = btffa_pkg::TagW'(r_s | OW'(1));
            end
            btffa_pkg::OP_RD_NXT: begin
                mem_re = 1'b1; mem_addr = r_p + T2 + r_s;
            end
            btffa_pkg::OP_RD_PRV: begin
                mem_re = 1'b1; mem_addr = r_p - T1;
            end
            btffa_pkg::OP_WR_F0: begin
                mem_we = 1'b1; mem_addr = r_hdr;
                mem_wdata = btffa_pkg::TagW'(r_sz);
            end
            btffa_pkg::OP_WR_F1: begin
                mem_we = 1'b1; mem_addr = r_hdr + T1 + r_sz;
                mem_wdata = btffa_pkg::TagW'(r_sz);
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_addr[btffa_pkg::AddrW:1]] <= mem_wdata;
        if (mem_re)
            r_rdata <= r_mem[mem_addr[btffa_pkg::AddrW:1]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cfg <= btffa_pkg::CfgW'(btffa_pkg::ArenaCap);
        else if (i_cfg_we)
            r_cfg <= i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            btffa_pkg::OP_LOAD: begin
                r_p    <= T1;
                r_need <= ({2'b0, i_word.request_size} + OW'(1)) & ~OW'(1);
                r_off  <= {2'b0, i_word.payload_offset};
                r_res  <= '0;
            end
            btffa_pkg::OP_FMT0: begin
                r_a   <= a_clamp;
                r_end <= a_clamp;
            end
            btffa_pkg::OP_LAT_P: begin
                r_s    <= rd_s;
                r_used <= r_rdata[0];
            end
            btffa_pkg::OP_ADV: r_p <= r_p + T2 + r_s;
            btffa_pkg::OP_FAIL: r_res.status <= 1'b1;
            btffa_pkg::OP_ALLOC_OK: r_res.alloc_offset <= 16'(r_p + T1);
            btffa_pkg::OP_CHK: begin
                r_res.owned  <= r_used;
                r_res.status <= !r_used;
            end
            btffa_pkg::OP_FREE_INIT: begin
                r_hdr <= r_p;
                r_sz  <= r_s;
            end
            btffa_pkg::OP_LAT_NXT:
                if (!r_rdata[0]) r_sz <= r_sz + T2 + rd_s;
            btffa_pkg::OP_LAT_PRV:
                if (!r_rdata[0] && (r_p >= T3 + rd_s)) begin
                    r_hdr <= r_p - T2 - rd_s;
                    r_sz  <= r_sz + T2 + rd_s;
                end
            default: r_p <= r_p;
        endcase
    end
endmodule

// ----- src/boundary_tag_first_fit_allocator_core.sv -----
// Format writes the arena end tag and the header and footer of one free block. Allocate,
// free and check walk the tags one block at a time; a walk off the end fails. On a hit,
// allocate takes the whole block or splits it, and free merges it with free neighbours.
// One word at a time over a single-port tag memory; next word taken after o_done; no stall.
// Synchronous active-low reset; after reset the arena is formatted at 65536 bytes
// as one free block while busy, with no result word.
`timescale 1ns / 1ps
module boundary_tag_first_fit_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  btffa_pkg::t_in_word         i_word,
    output logic                        o_busy,
    output logic                        o_done,
    output btffa_pkg::t_out_word        o_word,
    input  logic                        i_cfg_we,
    input  logic [btffa_pkg::CfgW-1:0]  i_cfg_wdata
);
    btffa_pkg::t_dp_cmd  cmd;
    btffa_pkg::t_dp_stat stat;

    btffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_word.kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    btffa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_word      (o_word)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done strobe held");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("accepted word not busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done while idle");
    a_boot: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_busy && !o_done)) else $error("no boot format");
endmodule

// ----- verif/tb_top.sv -----
// Testbench for the boundary tag first fit allocator: directed and random heap traffic.
`timescale 1ns / 1ps
module tb_top;
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    btffa_pkg::t_in_word  i_word;
    logic                 o_busy;
    logic                 o_done;
    btffa_pkg::t_out_word o_word;
    logic                 i_cfg_we;
    logic [btffa_pkg::CfgW-1:0] i_cfg_wdata;

    boundary_tag_first_fit_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_word      (i_word),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    int unsigned heap_tags [btffa_pkg::TagDepth];
    int unsigned arena_reg;
    btffa_pkg::t_out_word pending_replies [$];
    int unsigned live_offsets [$];
    int          mismatches;
    int          idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #1000ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned tag_rd(int unsigned off);
        int unsigned idx;
        idx = off >> 1;
        return (idx < btffa_pkg::TagDepth) ? heap_tags[idx] : 0;
    endfunction

    function automatic void tag_wr(int unsigned off, int unsigned v);
        int unsigned idx;
        idx = off >> 1;
        if (idx < btffa_pkg::TagDepth) heap_tags[idx] = v;
    endfunction

    function automatic void mark_block(int unsigned hdr, int unsigned size, int unsigned used);
        tag_wr(hdr, size | used);
        tag_wr(hdr + btffa_pkg::TagSpan + size, size | used);
    endfunction

    function automatic void format_heap();
        int unsigned a;
        a = (arena_reg + 1) & ~32'd1;
        if (a < 3 * btffa_pkg::TagSpan) a = 3 * btffa_pkg::TagSpan;
        if (a > btffa_pkg::TagDepth * 2) a = btffa_pkg::TagDepth * 2;
        tag_wr(0, a - btffa_pkg::TagSpan);
        mark_block(btffa_pkg::TagSpan, a - 3 * btffa_pkg::TagSpan, 0);
    endfunction

    function automatic bit alloc_block(int unsigned req, output int unsigned where);
        int unsigned need, lim, p, t, s;
        need = (req + 1) & ~32'd1;
        lim = tag_rd(0) + btffa_pkg::TagSpan;
        p = btffa_pkg::TagSpan;
        where = 0;
        while (p < lim) begin
            t = tag_rd(p);
            s = t & ~32'd1;
            if (t[0] == 1'b0 && s >= need) begin
                if (s - need >= 2 * btffa_pkg::TagSpan + btffa_pkg::MinSplit) begin
                    mark_block(p, need, 1);
                    mark_block(p + 2 * btffa_pkg::TagSpan + need,
                               s - need - 2 * btffa_pkg::TagSpan, 0);
                end else begin
                    mark_block(p, s, 1);
                end
                where = p + btffa_pkg::TagSpan;
                return 1'b0;
            end
            p += 2 * btffa_pkg::TagSpan + s;
        end
        return 1'b1;
    endfunction

    function automatic bit free_block(int unsigned off);
        int unsigned lim, p, t, s, hdr, nxt, tn, tp, sp;
        lim = tag_rd(0) + btffa_pkg::TagSpan;
        p = btffa_pkg::TagSpan;
        while (p < lim) begin
            t = tag_rd(p);
            s = t & ~32'd1;
            if (p + btffa_pkg::TagSpan == off) begin
                hdr = p;
                if (t[0] == 1'b0) return 1'b1;
                nxt = p + 2 * btffa_pkg::TagSpan + s;
                if (nxt < lim) begin
                    tn = tag_rd(nxt);
                    if (tn[0] == 1'b0) s += 2 * btffa_pkg::TagSpan + (tn & ~32'd1);
                end
                if (p > btffa_pkg::TagSpan) begin
                    tp = tag_rd(p - btffa_pkg::TagSpan);
                    sp = tp & ~32'd1;
                    if (tp[0] == 1'b0 && p >= 3 * btffa_pkg::TagSpan + sp) begin
                        hdr = p - 2 * btffa_pkg::TagSpan - sp;
                        s += 2 * btffa_pkg::TagSpan + sp;
                    end
                end
                mark_block(hdr, s, 0);
                return 1'b0;
            end
            if (p + btffa_pkg::TagSpan > off) return 1'b1;
            p += 2 * btffa_pkg::TagSpan + s;
        end
        return 1'b1;
    endfunction

    function automatic bit owns_offset(int unsigned off);
        int unsigned lim, p, t, s;
        lim = tag_rd(0) + btffa_pkg::TagSpan;
        p = btffa_pkg::TagSpan;
        while (p < lim) begin
            t = tag_rd(p);
            s = t & ~32'd1;
            if (off >= p + btffa_pkg::TagSpan && off < p + btffa_pkg::TagSpan + s) return t[0];
            p += 2 * btffa_pkg::TagSpan + s;
        end
        return 1'b0;
    endfunction

    function automatic btffa_pkg::t_out_word predict_reply(btffa_pkg::t_in_word w);
        btffa_pkg::t_out_word r;
        int unsigned where;
        r = '0;
        case (w.kind)
            btffa_pkg::KIND_FORMAT: begin
                format_heap();
                live_offsets.delete();
            end
            btffa_pkg::KIND_ALLOC: begin
                r.status = alloc_block(w.request_size, where);
                if (!r.status) begin
                    r.alloc_offset = where[15:0];
                    live_offsets.push_back(where);
                end
            end
            btffa_pkg::KIND_FREE: begin
                r.status = free_block(w.payload_offset);
                if (!r.status)
                    foreach (live_offsets[i])
                        if (live_offsets[i] == w.payload_offset) begin
                            live_offsets.delete(i);
                            break;
                        end
            end
            default: begin
                r.owned = owns_offset(w.payload_offset);
                r.status = ~r.owned;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        btffa_pkg::t_out_word exp_w;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_word);
            end else begin
                exp_w = pending_replies.pop_front();
                if (o_word.status !== exp_w.status || o_word.alloc_offset !== exp_w.alloc_offset
                        || o_word.owned !== exp_w.owned) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: exp st=%0d off=%0d own=%0d got st=%0d off=%0d own=%0d",
                                 exp_w.status, exp_w.alloc_offset, exp_w.owned,
                                 o_word.status, o_word.alloc_offset, o_word.owned);
                end
            end
        end
    end

    task automatic send_word(btffa_pkg::t_kind k, int unsigned req, int unsigned off);
        btffa_pkg::t_in_word w;
        w.kind = k;
        w.request_size = req[15:0];
        w.payload_offset = off[15:0];
        i_word = w;
        i_start = 1'b1;
        while (o_busy) @(negedge i_clk);
        pending_replies.push_back(predict_reply(w));
        @(negedge i_clk);
        i_start = 1'b0;
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending_replies.size() != 0 || o_busy) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_arena(int unsigned bytes);
        drain();
        i_cfg_wdata = bytes[btffa_pkg::CfgW-1:0];
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        arena_reg = bytes & 32'h1FFFF;
        send_word(btffa_pkg::KIND_FORMAT, $urandom, $urandom);
    endtask

    task automatic test_directed();
        int unsigned a0, a1;
        idle_pct = 0;
        send_word(btffa_pkg::KIND_CHECK, 0, 0);
        send_word(btffa_pkg::KIND_ALLOC, 0, 0);
        a0 = btffa_pkg::TagSpan * 2;
        send_word(btffa_pkg::KIND_CHECK, 0, a0);
        send_word(btffa_pkg::KIND_ALLOC, 1, 0);
        a1 = a0 + 2 * btffa_pkg::TagSpan;
        send_word(btffa_pkg::KIND_CHECK, 0, a1 + 1);
        send_word(btffa_pkg::KIND_CHECK, 0, a1 + 2);
        send_word(btffa_pkg::KIND_ALLOC, 65535, 0);
        send_word(btffa_pkg::KIND_ALLOC, 7, 0);
        send_word(btffa_pkg::KIND_FREE, 0, a1 + 1);
        send_word(btffa_pkg::KIND_FREE, 0, a1);
        send_word(btffa_pkg::KIND_FREE, 0, a1);
        send_word(btffa_pkg::KIND_FREE, 0, 65535);
        send_word(btffa_pkg::KIND_FREE, 0, a0);
        send_word(btffa_pkg::KIND_CHECK, 0, 65535);
        send_word(btffa_pkg::KIND_ALLOC, 65536 - 3 * btffa_pkg::TagSpan, 0);
        send_word(btffa_pkg::KIND_ALLOC, 65536 - 3 * btffa_pkg::TagSpan, 0);
        send_word(btffa_pkg::KIND_FORMAT, 16'hFFFF, 16'hFFFF);
        send_word(btffa_pkg::KIND_ALLOC, 65536 - 5 * btffa_pkg::TagSpan - 5, 0);
        send_word(btffa_pkg::KIND_ALLOC, 0, 0);
    endtask

    task automatic test_small_arena();
        idle_pct = 7;
        set_arena(0);
        send_word(btffa_pkg::KIND_ALLOC, 0, 0);
        send_word(btffa_pkg::KIND_ALLOC, 0, 0);
        send_word(btffa_pkg::KIND_FREE, 0, 2 * btffa_pkg::TagSpan);
        set_arena(3 * btffa_pkg::TagSpan + 2 * btffa_pkg::TagSpan + 6);
        send_word(btffa_pkg::KIND_ALLOC, 0, 0);
        send_word(btffa_pkg::KIND_ALLOC, 6, 0);
        send_word(btffa_pkg::KIND_FREE, 0, 2 * btffa_pkg::TagSpan);
        send_word(btffa_pkg::KIND_FREE, 0, 4 * btffa_pkg::TagSpan);
        send_word(btffa_pkg::KIND_ALLOC, 2 * btffa_pkg::TagSpan + 6, 0);
        set_arena(1001);
        send_word(btffa_pkg::KIND_CHECK, 0, 1000);
    endtask

    task automatic test_random(int unsigned bytes, int n, int pct);
        int unsigned r, base;
        set_arena(bytes);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 2) begin
                send_word(btffa_pkg::KIND_FORMAT, $urandom, $urandom);
            end else if (r < 45) begin
                if ($urandom_range(9) == 0)
                    send_word(btffa_pkg::KIND_ALLOC, $urandom, $urandom);
                else
                    send_word(btffa_pkg::KIND_ALLOC, $urandom_range(bytes / 8 + 8), $urandom);
            end else if (r < 75) begin
                if (live_offsets.size() != 0 && $urandom_range(9) < 8)
                    send_word(btffa_pkg::KIND_FREE, $urandom,
                              live_offsets[$urandom_range(live_offsets.size() - 1)]);
                else
                    send_word(btffa_pkg::KIND_FREE, $urandom, $urandom);
            end else begin
                if (live_offsets.size() != 0 && $urandom_range(9) < 7) begin
                    base = live_offsets[$urandom_range(live_offsets.size() - 1)];
                    send_word(btffa_pkg::KIND_CHECK, $urandom, base + $urandom_range(40) - 10);
                end else begin
                    send_word(btffa_pkg::KIND_CHECK, $urandom, $urandom);
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        mismatches = 0;
        idle_pct = 0;
        arena_reg = 65536;
        foreach (heap_tags[i]) heap_tags[i] = 0;
        format_heap();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_small_arena();
        test_random(2048, 450, 0);
        test_random(600, 400, 77);
        test_random(24 + $urandom_range(3000), 400, 7);
        test_random(131071, 200, 0);
        test_random(300, 250, 77);
        drain();
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
